// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);
// Property checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, cond, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`endif
`endif

// ===== rtl/otpwb_pkg.sv =====
// Types and constants of the OTP white balance gain block.
// No dependencies.
package otpwb_pkg;

    localparam int RATIO_W = 10;
    localparam int Q_W     = 20;  // golden * 1000 fits in 20 bits
    localparam int GNUM_W  = 28;  // quotient shifted by eight
    localparam int GAIN_W  = 16;
    localparam int DIV_BPS = 4;   // quotient bits resolved per divider stage

    typedef logic [RATIO_W-1:0] ratio_t;
    typedef logic [Q_W-1:0]     quot_t;
    typedef logic [GAIN_W-1:0]  gain_t;

    localparam quot_t  GAIN_SCALE  = quot_t'(1000);
    localparam int     UNITY_GAIN  = 256;
    localparam gain_t  GAIN_MAX    = 16'hFFFF;
    localparam ratio_t RST_GOLDEN_RED  = ratio_t'(304);
    localparam ratio_t RST_GOLDEN_BLUE = ratio_t'(254);
    localparam ratio_t RST_GOLDEN_GB   = ratio_t'(512);
    localparam logic [1:0] GROUP_VALID = 2'b01;

    typedef enum logic [1:0] {
        REG_GOLDEN_RED  = 2'd0,
        REG_GOLDEN_BLUE = 2'd1,
        REG_GOLDEN_GB   = 2'd2
    } cfg_reg_e;

endpackage

// ===== rtl/otp_white_balance_gain_top.sv =====
// Pipeline: input stage, 5 ratio divider stages, base stage, 7 gain divider
// stages and the output register. Throughput one record per cycle; every stage holds
// while the output register is full and not taken. Synchronous active-low reset
// empties the pipeline and loads the golden ratios 304, 254 and 512.
`include "assert_macros.svh"
module otp_white_balance_gain_top
    import otpwb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [9:0]   cfg_wr_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_group_flags,
    input  logic [7:0]   s_first_red_high,
    input  logic [7:0]   s_first_blue_high,
    input  logic [7:0]   s_first_gb_high,
    input  logic [7:0]   s_first_low_bits,
    input  logic [7:0]   s_second_red_high,
    input  logic [7:0]   s_second_blue_high,
    input  logic [7:0]   s_second_gb_high,
    input  logic [7:0]   s_second_low_bits,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_applied,
    output logic [15:0]  m_gr_gain,
    output logic         m_gr_write,
    output logic [15:0]  m_red_gain,
    output logic         m_red_write,
    output logic [15:0]  m_blue_gain,
    output logic         m_blue_write,
    output logic [15:0]  m_gb_gain,
    output logic         m_gb_write
);

    ratio_t gold_red_reg, gold_blue_reg, gold_gb_reg;
    logic   en;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gold_red_reg  <= RST_GOLDEN_RED;
            gold_blue_reg <= RST_GOLDEN_BLUE;
            gold_gb_reg   <= RST_GOLDEN_GB;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GOLDEN_RED:  gold_red_reg  <= cfg_wr_data;
                REG_GOLDEN_BLUE: gold_blue_reg <= cfg_wr_data;
                REG_GOLDEN_GB:   gold_gb_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input stage: group choice and golden numerators.
    ratio_t r_next, b_next, gb_next;
    logic   in_vld_reg, in_ok_reg;
    logic [2:0][Q_W-1:0]     in_num_reg;
    logic [2:0][RATIO_W-1:0] in_den_reg;

    always_comb begin
        r_next  = '0;
        b_next  = '0;
        gb_next = '0;
        if (s_group_flags[7:6] == GROUP_VALID) begin
            r_next  = {s_first_red_high,  s_first_low_bits[7:6]};
            b_next  = {s_first_blue_high, s_first_low_bits[5:4]};
            gb_next = {s_first_gb_high,   s_first_low_bits[3:2]};
        end else if (s_group_flags[5:4] == GROUP_VALID) begin
            r_next  = {s_second_red_high,  s_second_low_bits[7:6]};
            b_next  = {s_second_blue_high, s_second_low_bits[5:4]};
            gb_next = {s_second_gb_high,   s_second_low_bits[3:2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_ok_reg     <= (r_next != '0) && (b_next != '0) && (gb_next != '0);
            in_num_reg[0] <= Q_W'(gold_red_reg  * GAIN_SCALE);
            in_num_reg[1] <= Q_W'(gold_blue_reg * GAIN_SCALE);
            in_num_reg[2] <= Q_W'(gold_gb_reg   * GAIN_SCALE);
            in_den_reg    <= {gb_next, b_next, r_next};
        end
    end

    logic                    q_vld, q_ok;
    logic [2:0][Q_W-1:0]     q_quo;

    otpwb_div_pipe #(
        .LANES(3), .NUM_W(Q_W), .DEN_W(RATIO_W), .BPS(DIV_BPS), .SIDE_W(1)
    ) u_ratio_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_vld_reg), .in_num(in_num_reg), .in_den(in_den_reg),
        .in_side(in_ok_reg),
        .out_valid(q_vld), .out_quo(q_quo), .out_side(q_ok)
    );

    // Base stage: smallest quotient, capped at unity scale.
    quot_t base_next;
    logic  bs_vld_reg, bs_ok_reg;
    logic [3:0][GNUM_W-1:0]  bs_num_reg;
    ratio_t                  bs_base_reg;

    always_comb begin
        base_next = GAIN_SCALE;
        for (int l = 0; l < 3; l++) begin
            if (q_quo[l] < base_next) begin
                base_next = q_quo[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_vld_reg <= 1'b0;
        end else if (en) begin
            bs_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bs_ok_reg     <= q_ok && (base_next != '0);
            bs_base_reg   <= base_next[RATIO_W-1:0];
            bs_num_reg[0] <= {GAIN_SCALE, 8'h00};
            bs_num_reg[1] <= {q_quo[0], 8'h00};
            bs_num_reg[2] <= {q_quo[1], 8'h00};
            bs_num_reg[3] <= {q_quo[2], 8'h00};
        end
    end

    logic                    g_vld, g_ok;
    logic [3:0][GNUM_W-1:0]  g_quo;

    otpwb_div_pipe #(
        .LANES(4), .NUM_W(GNUM_W), .DEN_W(RATIO_W), .BPS(DIV_BPS), .SIDE_W(1)
    ) u_gain_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(bs_vld_reg), .in_num(bs_num_reg),
        .in_den({4{bs_base_reg}}), .in_side(bs_ok_reg),
        .out_valid(g_vld), .out_quo(g_quo), .out_side(g_ok)
    );

    // Output register.
    logic              out_vld_reg, out_app_reg;
    logic [3:0][15:0]  out_gain_reg;
    logic [3:0]        out_wr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= g_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_app_reg <= g_ok;
            for (int l = 0; l < 4; l++) begin
                if (!g_ok) begin
                    out_gain_reg[l] <= '0;
                end else if (g_quo[l] > GNUM_W'(GAIN_MAX)) begin
                    out_gain_reg[l] <= GAIN_MAX;
                end else begin
                    out_gain_reg[l] <= g_quo[l][GAIN_W-1:0];
                end
                out_wr_reg[l] <= g_ok && (g_quo[l] > GNUM_W'(UNITY_GAIN));
            end
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_applied    = out_app_reg;
    assign m_gr_gain    = out_gain_reg[0];
    assign m_red_gain   = out_gain_reg[1];
    assign m_blue_gain  = out_gain_reg[2];
    assign m_gb_gain    = out_gain_reg[3];
    assign m_gr_write   = out_wr_reg[0];
    assign m_red_write  = out_wr_reg[1];
    assign m_blue_write = out_wr_reg[2];
    assign m_gb_write   = out_wr_reg[3];

    `ASSERT_ALWAYS(a_ready_follows_stall, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready does not follow output stall")
    `ASSERT_IMPL(a_rejected_zero, aclk, aresetn, m_valid && !m_applied, (m_gr_gain | m_red_gain | m_blue_gain | m_gb_gain) == 16'd0, "rejected record carries gains")
    `ASSERT_IMPL(a_gr_at_least_unity, aclk, aresetn, m_valid && m_applied, m_gr_gain >= 16'd256, "Gr gain below unity")
    `ASSERT_IMPL(a_red_write_mark, aclk, aresetn, m_valid && m_red_write, m_red_gain > 16'd256, "R write mark without gain above unity")

endmodule

// ===== rtl/otpwb_div_pipe.sv =====
// Pipelined restoring divider with several lanes sharing one valid and sideband.
// Uses no package; each stage resolves BPS quotient bits and holds on !en.
module otpwb_div_pipe #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 20,
    parameter int DEN_W  = 10,
    parameter int BPS    = 4,
    parameter int SIDE_W = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]      in_num,
    input  logic [LANES-1:0][DEN_W-1:0]      in_den,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][NUM_W-1:0]      out_quo,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int STAGES = NUM_W / BPS;

    // The numerator word shifts out at the top while quotient bits enter at the bottom.
    logic [LANES-1:0][NUM_W-1:0] num_reg  [STAGES+1];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [STAGES+1];
    logic [LANES-1:0][DEN_W-1:0] den_reg  [STAGES+1];
    logic [SIDE_W-1:0]           side_reg [STAGES+1];
    logic                        vld_reg  [STAGES+1];

    assign num_reg[0]  = in_num;
    assign rem_reg[0]  = '0;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;
    assign vld_reg[0]  = in_valid;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [LANES-1:0][NUM_W-1:0] num_next;
        logic [LANES-1:0][DEN_W-1:0] rem_next;

        always_comb begin
            logic [NUM_W-1:0] n;
            logic [DEN_W-1:0] r;
            logic [DEN_W:0]   t;
            for (int l = 0; l < LANES; l++) begin
                n = num_reg[s][l];
                r = rem_reg[s][l];
                for (int b = 0; b < BPS; b++) begin
                    t = {r, n[NUM_W-1]};
                    n = {n[NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, den_reg[s][l]}) begin
                        t = t - {1'b0, den_reg[s][l]};
                        n[0] = 1'b1;
                    end
                    r = t[DEN_W-1:0];
                end
                num_next[l] = n;
                rem_next[l] = r;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[s+1]  <= num_next;
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_quo   = num_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule
